### design/tab_separated_record_receiver_defines.svh
// assertion helpers for the record receiver
`ifndef TAB_SEPARATED_RECORD_RECEIVER_DEFINES_SVH
`define TAB_SEPARATED_RECORD_RECEIVER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/tsr_pkg.sv
package tsr_pkg;

    localparam int ROM_SIZE = 51;

    typedef enum logic [1:0] {
        EV_FIELD = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        PS_SYNC  = 2'd0,
        PS_LABEL = 2'd1,
        PS_VALUE = 2'd2
    } t_parse;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;

    // packed label text, first character in the low byte
    typedef struct packed {
        logic [63:0] text;
        logic [3:0]  len;
    } t_label;

    localparam t_label CHECKSUM_LABEL = '{64'h6d75736b63656843, 4'd8};

    // label table
    function automatic t_label rom_label(input logic [5:0] idx);
        t_label r;
        r = '{64'd0, 4'd0};
        case (idx)
            6'd0:  r = '{64'h56, 4'd1};
            6'd1:  r = '{64'h5356, 4'd2};
            6'd2:  r = '{64'h4d56, 4'd2};
            6'd3:  r = '{64'h4d44, 4'd2};
            6'd4:  r = '{64'h565056, 4'd3};
            6'd5:  r = '{64'h565050, 4'd3};
            6'd6:  r = '{64'h49, 4'd1};
            6'd7:  r = '{64'h4c49, 4'd2};
            6'd8:  r = '{64'h44414f4c, 4'd4};
            6'd9:  r = '{64'h54, 4'd1};
            6'd10: r = '{64'h50, 4'd1};
            6'd11: r = '{64'h4543, 4'd2};
            6'd12: r = '{64'h434f53, 4'd3};
            6'd13: r = '{64'h475454, 4'd3};
            6'd14: r = '{64'h6d72616c41, 4'd5};
            6'd15: r = '{64'h79616c6552, 4'd5};
            6'd16: r = '{64'h5241, 4'd2};
            6'd17: r = '{64'h3148, 4'd2};
            6'd18: r = '{64'h3248, 4'd2};
            6'd19: r = '{64'h3348, 4'd2};
            6'd20: r = '{64'h3448, 4'd2};
            6'd21: r = '{64'h3548, 4'd2};
            6'd22: r = '{64'h3648, 4'd2};
            6'd23: r = '{64'h3748, 4'd2};
            6'd24: r = '{64'h3848, 4'd2};
            6'd25: r = '{64'h3948, 4'd2};
            6'd26: r = '{64'h303148, 4'd3};
            6'd27: r = '{64'h313148, 4'd3};
            6'd28: r = '{64'h323148, 4'd3};
            6'd29: r = '{64'h333148, 4'd3};
            6'd30: r = '{64'h343148, 4'd3};
            6'd31: r = '{64'h353148, 4'd3};
            6'd32: r = '{64'h363148, 4'd3};
            6'd33: r = '{64'h373148, 4'd3};
            6'd34: r = '{64'h383148, 4'd3};
            6'd35: r = '{64'h393148, 4'd3};
            6'd36: r = '{64'h303248, 4'd3};
            6'd37: r = '{64'h313248, 4'd3};
            6'd38: r = '{64'h323248, 4'd3};
            6'd39: r = '{64'h333248, 4'd3};
            6'd40: r = '{64'h525245, 4'd3};
            6'd41: r = '{64'h5343, 4'd2};
            6'd42: r = '{64'h564d42, 4'd3};
            6'd43: r = '{64'h5746, 4'd2};
            6'd44: r = '{64'h444950, 4'd3};
            6'd45: r = '{64'h23524553, 4'd4};
            6'd46: r = '{64'h53445348, 4'd4};
            6'd47: r = '{64'h45444f4d, 4'd4};
            6'd48: r = '{64'h565f54554f5f4341, 4'd8};
            6'd49: r = '{64'h495f54554f5f4341, 4'd8};
            6'd50: r = '{64'h4e524157, 4'd4};
            default: r = '{64'd0, 4'd0};
        endcase
        return r;
    endfunction

endpackage

### design/tab_separated_record_receiver.sv
// channel | direction | handshake         | payload
// input   | in        | i_valid / o_stall | i_rx_byte
// output  | out       | o_valid / i_stall | o_event_res .. o_last
// ordinary byte: parsed as taken; field line end: label search, one table slot a
// cycle (up to NSLOT); good checksum: a walk that reads and emits each dirty slot
// (ram read, emit) up to the last dirty one (all slots when none is dirty), then
// the end marker; every result waits out output stalls. o_stall is high while a
// walk runs or a result waits. reset is synchronous and clears control state and
// dirty marks; the pending-value ram is not cleared.
`include "tab_separated_record_receiver_defines.svh"
module tab_separated_record_receiver #(
    parameter int NUM_LABELS  = 51,
    parameter int VALUE_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_res,
    output logic [5:0]  o_field_index,
    output logic [63:0] o_value_chars,
    output logic [3:0]  o_value_length,
    output logic        o_truncated,
    output logic        o_last
);
    import tsr_pkg::*;

    localparam int NSLOT = (NUM_LABELS < ROM_SIZE) ? NUM_LABELS : ROM_SIZE;
    localparam int AW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int PW    = 64 + 4 + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_READ   = 5'b00100,
        S_EMIT   = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    t_parse       r_parse;
    logic [7:0]   r_sum;
    logic [63:0]  r_label;
    logic [3:0]   r_lcnt;
    logic [63:0]  r_value;
    logic [3:0]   r_vcnt;
    logic         r_vovf;
    logic [NSLOT-1:0] r_dirty;
    logic [5:0]   r_idx;
    logic         r_end_pending;

    logic         r_ovalid;
    logic [1:0]   r_ev;
    logic [5:0]   r_fidx;
    logic [63:0]  r_ochars;
    logic [3:0]   r_olen;
    logic         r_otr;
    logic         r_olast;

    logic         in_xfer, out_xfer;
    logic         ram_we;
    logic [PW-1:0] ram_rdata;
    t_label       cur;
    logic         hit;
    logic         is_cks;
    logic [7:0]   sum_next;
    logic         more_dirty;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_ovalid && !i_stall;
    assign o_stall  = (r_state != S_IDLE) || r_ovalid;
    assign sum_next = r_sum + i_rx_byte;

    // shared label comparator against the table slot at r_idx
    assign cur = rom_label(r_idx);
    assign hit = (cur.len == r_lcnt) && (cur.text == r_label);
    assign is_cks = (r_lcnt == CHECKSUM_LABEL.len) && (r_label == CHECKSUM_LABEL.text);

    // any dirty slot beyond the current one
    always_comb begin
        more_dirty = 1'b0;
        for (int k = 0; k < NSLOT; k++) begin
            if (k > int'(r_idx) && r_dirty[k]) more_dirty = 1'b1;
        end
    end

    assign ram_we = (r_state == S_SEARCH) && hit;

    tsr_ram #(.WIDTH(PW), .DEPTH(NSLOT)) u_pend (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata ({r_value, r_vcnt, r_vovf}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && r_parse == PS_VALUE && i_rx_byte == CH_LF) begin
                    if (is_cks) begin
                        n_state = (sum_next == 8'd0) ? S_READ : S_OUT;
                    end else if (r_lcnt != 4'd0 && r_lcnt <= 4'd8) begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (hit || int'(r_idx) == NSLOT - 1) n_state = S_IDLE;
            end
            S_READ: begin
                if (!r_ovalid || out_xfer) begin
                    n_state = r_dirty[r_idx[AW-1:0]] ? S_EMIT : S_OUT;
                    if (!r_dirty[r_idx[AW-1:0]] && int'(r_idx) != NSLOT - 1) n_state = S_READ;
                end
            end
            S_EMIT:  n_state = more_dirty ? S_READ : S_OUT;
            S_OUT:   if (!r_ovalid || out_xfer) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_parse  <= PS_SYNC;
            r_sum    <= 8'd0;
            r_label  <= 64'd0;
            r_lcnt   <= 4'd0;
            r_value  <= 64'd0;
            r_vcnt   <= 4'd0;
            r_vovf   <= 1'b0;
            r_dirty  <= '0;
            r_idx    <= 6'd0;
            r_ovalid <= 1'b0;
            r_end_pending <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_xfer && r_state != S_OUT) r_ovalid <= 1'b0;
            // byte parsing
            if (in_xfer) begin
                r_sum <= (r_parse == PS_VALUE && i_rx_byte == CH_LF && is_cks) ?
                         8'd0 : sum_next;
                r_idx <= 6'd0;
                case (r_parse)
                    PS_LABEL: begin
                        if (i_rx_byte == CH_TAB) begin
                            r_parse <= PS_VALUE;
                            r_value <= 64'd0;
                            r_vcnt  <= 4'd0;
                            r_vovf  <= 1'b0;
                        end else begin
                            if (r_lcnt < 4'd8) r_label[r_lcnt[2:0]*8 +: 8] <= i_rx_byte;
                            if (r_lcnt <= 4'd8) r_lcnt <= r_lcnt + 4'd1;
                        end
                    end
                    PS_VALUE: begin
                        if (i_rx_byte == CH_LF) begin
                            r_parse <= PS_LABEL;
                            r_end_pending <= is_cks && sum_next == 8'd0;
                        end else if (i_rx_byte != CH_CR) begin
                            if (r_vcnt < 4'(VALUE_CHARS)) begin
                                r_value[r_vcnt[2:0]*8 +: 8] <= i_rx_byte;
                                r_vcnt <= r_vcnt + 4'd1;
                            end else begin
                                r_vovf <= 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (i_rx_byte == CH_LF) r_parse <= PS_LABEL;
                    end
                endcase
            end
            // label is cleared once the walk that uses it is done, or at a line end that starts no walk
            if (r_state != S_IDLE && n_state == S_IDLE) begin
                r_label <= 64'd0;
                r_lcnt  <= 4'd0;
            end
            if (in_xfer && r_parse == PS_VALUE && i_rx_byte == CH_LF
                    && n_state == S_IDLE) begin
                r_label <= 64'd0;
                r_lcnt  <= 4'd0;
            end
            case (r_state)
                S_SEARCH: begin
                    if (hit) r_dirty[r_idx[AW-1:0]] <= 1'b1;
                    else r_idx <= r_idx + 6'd1;
                end
                S_READ: begin
                    if ((!r_ovalid || out_xfer) && !r_dirty[r_idx[AW-1:0]]
                            && int'(r_idx) != NSLOT - 1) begin
                        r_idx <= r_idx + 6'd1;
                    end
                end
                S_EMIT: begin
                    r_ovalid <= 1'b1;
                    r_ev     <= EV_FIELD;
                    r_fidx   <= r_idx;
                    r_ochars <= ram_rdata[PW-1 -: 64];
                    r_olen   <= ram_rdata[4:1];
                    r_otr    <= ram_rdata[0];
                    r_olast  <= 1'b0;
                    r_dirty[r_idx[AW-1:0]] <= 1'b0;
                    if (int'(r_idx) != NSLOT - 1) r_idx <= r_idx + 6'd1;
                    else r_idx <= 6'd0;
                end
                S_OUT: begin
                    if (!r_ovalid || out_xfer) begin
                        r_ovalid <= 1'b1;
                        r_ev     <= r_end_pending ? EV_END : EV_ERROR;
                        r_fidx   <= 6'd0;
                        r_ochars <= 64'd0;
                        r_olen   <= 4'd0;
                        r_otr    <= 1'b0;
                        r_olast  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_event_res    = r_ev;
    assign o_field_index  = r_fidx;
    assign o_value_chars  = r_ochars;
    assign o_value_length = r_olen;
    assign o_truncated    = r_otr;
    assign o_last         = r_olast;

    // checks on the sequencer
    `TSR_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `TSR_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `TSR_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, r_state == S_EMIT, o_valid)
    `TSR_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_state == S_SEARCH, int'(r_idx) < NSLOT)
endmodule

### design/tsr_ram.sv
module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
